// ===== sv/elpi_pkg.sv =====
// Shared widths, constants and types of the electronic load PI controller.
package elpi_pkg;

    localparam int DAC_BITS_DEF = 12;

    localparam int VOLT_W     = 16;
    localparam int CUR_W      = 16;
    localparam int SETP_W     = 20;
    localparam int PGAIN_W    = 18;
    localparam int IGAIN_W    = 16;
    localparam int INTEG_W    = 27;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // voltage_mv * 1000 needs 26 bits
    localparam int DIVIDEND_W = 26;

    // Q16 gains: drop the fraction after the sum
    localparam int QSHIFT = 16;

    localparam logic [INTEG_W-1:0] INT_LIMIT   = 27'd81900000;
    localparam logic [SETP_W-1:0]  CR_MIN_MOHM = 20'd1000;
    localparam logic [VOLT_W-1:0]  CR_MIN_MV   = 16'd100;
    localparam logic [9:0]         MV_SCALE    = 10'd1000;

    localparam logic [PGAIN_W-1:0] PGAIN_RST = 18'd52429;
    localparam logic [IGAIN_W-1:0] IGAIN_RST = 16'd492;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOAD_MODE  = 3'd0,
        REG_SETPOINT   = 3'd1,
        REG_FORCE_STOP = 3'd2,
        REG_PROP_GAIN  = 3'd3,
        REG_INT_GAIN   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== sv/elpi_div.sv =====
// Radix-2 restoring serial divider for the constant-resistance target.
module elpi_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [elpi_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [elpi_pkg::SETP_W-1:0]      divisor,
    output elpi_pkg::div_status_t            status,
    output logic [elpi_pkg::DIVIDEND_W-1:0]  quotient
);
    import elpi_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SETP_W-1:0]     rem_reg;
    logic [SETP_W-1:0]     div_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [SETP_W:0]       trial;
    logic                  ge;
    logic [SETP_W:0]       diff;
    logic [SETP_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // One quotient bit per cycle: shift in the next dividend bit, try subtract
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge       = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = ge ? diff[SETP_W-1:0] : trial[SETP_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    // Sequence the iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Hold the partial remainder and the shifting quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== sv/electronic_load_pi_controller_unit.sv =====
// Electronic load PI current controller: one voltage and current sample in, one DAC code out.
// Each transaction of samples yields one DAC code. In constant-resistance mode with a
// valid setpoint and voltage the target current comes from a 26-step serial divider.
// Without a division, in constant-current mode or when the resistance target is forced
// to zero, the sample goes straight to evaluation. When the error is not positive or
// force stop is set, the code is forced to zero and no multiply is done. Otherwise the
// rest of the work runs on one shared 27x18 multiplier used twice, then one accumulate
// step. The input is ready only while no sample is being worked on. A finished code
// waits in the output register and the next sample is accepted meanwhile; a further
// finished code holds until the output register is taken. Any valid configuration
// write clears the error integral.
module electronic_load_pi_controller_unit #(
    parameter int DAC_BITS = elpi_pkg::DAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [elpi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [elpi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [elpi_pkg::VOLT_W-1:0]      s_voltage_mv,
    input  logic [elpi_pkg::CUR_W-1:0]       s_current_ma,
    // code output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [DAC_BITS-1:0]              m_dac_code
);
    import elpi_pkg::*;

    localparam int MUL_A_W = INTEG_W;
    localparam int MUL_B_W = PGAIN_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;
    localparam int CODE_W  = ACC_W - QSHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_MUL_P,
        ST_MUL_I,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t              state_reg;

    logic                load_mode_reg;
    logic [SETP_W-1:0]   setpoint_reg;
    logic                force_stop_reg;
    logic [PGAIN_W-1:0]  prop_gain_reg;
    logic [IGAIN_W-1:0]  int_gain_reg;

    logic [CUR_W-1:0]    cur_reg;
    logic [SETP_W-1:0]   target_reg;
    logic [SETP_W-1:0]   err_reg;
    logic [INTEG_W-1:0]  integ_reg;
    logic [INTEG_W-1:0]  integ_next;
    logic [ACC_W-1:0]    prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                m_valid_reg;
    logic [DAC_BITS-1:0] dac_reg;

    logic                accept;
    logic                cfg_hit;
    logic                cr_div;
    logic                stop;
    logic [SETP_W-1:0]   err;
    logic [INTEG_W:0]    integ_sum;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [ACC_W-1:0]    mul_out;
    logic [CODE_W-1:0]   code_wide;
    logic [DAC_BITS-1:0] code_sat;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    div_status_t           div_status;
    logic [DIVIDEND_W-1:0] div_quotient;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_dac_code = dac_reg;
    assign cfg_hit    = cfg_wr_en && (cfg_addr <= REG_INT_GAIN);

    // Resistance mode divides only for a usable setpoint and voltage
    assign cr_div       = load_mode_reg && (setpoint_reg >= CR_MIN_MOHM)
                          && (s_voltage_mv > CR_MIN_MV);
    assign div_start    = accept && cr_div;
    assign div_dividend = DIVIDEND_W'(s_voltage_mv) * DIVIDEND_W'(MV_SCALE);

    elpi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (setpoint_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Error, clamped integral and stop decision
    always_comb begin
        stop       = force_stop_reg || (target_reg <= SETP_W'(cur_reg));
        err        = target_reg - SETP_W'(cur_reg);
        integ_sum  = {1'b0, integ_reg} + (INTEG_W + 1)'(err);
        integ_next = integ_reg;
        if (cfg_hit) begin
            integ_next = '0;
        end else if (state_reg == ST_EVAL) begin
            if (stop) begin
                integ_next = '0;
            end else if (integ_sum > {1'b0, INT_LIMIT}) begin
                integ_next = INT_LIMIT;
            end else begin
                integ_next = integ_sum[INTEG_W-1:0];
            end
        end
    end

    // Shared multiplier: proportional term first, then integral term
    always_comb begin
        if (state_reg == ST_MUL_P) begin
            mul_a = MUL_A_W'(err_reg);
            mul_b = prop_gain_reg;
        end else begin
            mul_a = integ_reg;
            mul_b = MUL_B_W'(int_gain_reg);
        end
        mul_out = ACC_W'(mul_a) * ACC_W'(mul_b);
    end

    // Drop the Q16 fraction and saturate to full scale
    always_comb begin
        code_wide = acc_reg[ACC_W-1:QSHIFT];
        if (|code_wide[CODE_W-1:DAC_BITS]) begin
            code_sat = '1;
        end else begin
            code_sat = code_wide[DAC_BITS-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_mode_reg  <= 1'b0;
            setpoint_reg   <= '0;
            force_stop_reg <= 1'b0;
            prop_gain_reg  <= PGAIN_RST;
            int_gain_reg   <= IGAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_LOAD_MODE:  load_mode_reg  <= cfg_wdata[0];
                REG_SETPOINT:   setpoint_reg   <= cfg_wdata[SETP_W-1:0];
                REG_FORCE_STOP: force_stop_reg <= cfg_wdata[0];
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata[PGAIN_W-1:0];
                REG_INT_GAIN:   int_gain_reg   <= cfg_wdata[IGAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, integral and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            integ_reg <= integ_next;
            // Load a finished code, or drop the one just taken
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (cr_div) begin
                            state_reg <= ST_DIV;
                        end else begin
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (stop) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MUL_P;
                    end
                end
                ST_MUL_P: state_reg <= ST_MUL_I;
                ST_MUL_I: state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_OUT;
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cur_reg <= s_current_ma;
                    if (!load_mode_reg) begin
                        target_reg <= setpoint_reg;
                    end else begin
                        target_reg <= '0;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    target_reg <= div_quotient[SETP_W-1:0];
                end
            end
            ST_EVAL: begin
                err_reg <= err;
                acc_reg <= '0;
            end
            ST_MUL_P: prod_reg <= mul_out;
            ST_MUL_I: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_out;
            end
            ST_SUM: acc_reg <= acc_reg + prod_reg;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    dac_reg <= code_sat;
                end
            end
            default: ;
        endcase
    end

    // The integral never leaves its clamp
    a_integ_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        integ_reg <= INT_LIMIT)
        else $error("error integral above clamp");

    // A valid register write clears the integral
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> integ_reg == '0)
        else $error("integral not cleared by configuration write");

    // A resistance-mode sample starts the divider
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_status.busy && state_reg == ST_DIV)
        else $error("divider not started");

    // Divider completion moves on to evaluation
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_status.done) |=> state_reg == ST_EVAL)
        else $error("divider result not consumed");

endmodule

// ===== tb/sv/electronic_load_pi_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the electronic load PI controller with its own controller model.
module electronic_load_pi_controller_unit_tb;

    import elpi_pkg::*;

    localparam int          CLK_PERIOD  = 20;
    localparam int          DAC_W       = DAC_BITS_DEF;
    localparam int          SUM_W       = INTEG_W + 1;
    localparam int unsigned ITEMS       = 1550;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned IDLE_PCT    = 37;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_WAIT  = 64;
    localparam longint      TIMEOUT_NS  = 64'd20_000_000;

    localparam logic [DAC_W-1:0]      DAC_MAX         = '1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic [CUR_W-1:0]  current_ma;
    } sample_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [VOLT_W-1:0]     s_voltage_mv = '0;
    logic [CUR_W-1:0]      s_current_ma = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [DAC_W-1:0]      m_dac_code;

    // Mirror of the controller registers and the error integral
    logic               mode_cr = 1'b0;
    logic [SETP_W-1:0]  setp    = '0;
    logic               stop    = 1'b0;
    logic [PGAIN_W-1:0] kp      = PGAIN_RST;
    logic [IGAIN_W-1:0] ki      = IGAIN_RST;
    logic [INTEG_W-1:0] integ   = '0;

    sample_t          pending_samples[$];
    logic [DAC_W-1:0] expected_codes[$];

    int unsigned n_errors  = 0;
    int unsigned n_sent    = 0;
    logic        steady    = 1'b0;
    logic        hold_go   = 1'b0;
    int unsigned hold_left = 0;

    electronic_load_pi_controller_unit #(
        .DAC_BITS(DAC_W)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_voltage_mv(s_voltage_mv),
        .s_current_ma(s_current_ma),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dac_code  (m_dac_code)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Target current in mA for the present mode and setpoint
    function automatic logic [SETP_W-1:0] load_target(input logic [VOLT_W-1:0] v);
        logic [DIVIDEND_W-1:0] num;
        num = DIVIDEND_W'(v) * DIVIDEND_W'(MV_SCALE);
        if (!mode_cr)
            return setp;
        if (setp < CR_MIN_MOHM || v <= CR_MIN_MV)
            return '0;
        return SETP_W'(num / DIVIDEND_W'(setp));
    endfunction

    // Advance the PI loop by one sample and return the DAC code it drives
    function automatic logic [DAC_W-1:0] step_controller(input logic [VOLT_W-1:0] v,
                                                         input logic [CUR_W-1:0]  c);
        logic [SETP_W-1:0] tgt;
        logic [SETP_W-1:0] err;
        logic [SUM_W-1:0]  sum;
        logic [63:0]       acc;
        tgt = load_target(v);
        if (stop || tgt <= SETP_W'(c)) begin
            integ = '0;
            return '0;
        end
        err = tgt - SETP_W'(c);
        sum = SUM_W'(integ) + SUM_W'(err);
        if (sum > SUM_W'(INT_LIMIT))
            sum = SUM_W'(INT_LIMIT);
        integ = sum[INTEG_W-1:0];
        acc = (64'(err) * 64'(kp) + 64'(integ) * 64'(ki)) >> QSHIFT;
        if (acc > 64'(DAC_MAX))
            return DAC_MAX;
        return acc[DAC_W-1:0];
    endfunction

    // Driver: offer queued samples, predict the code of each accepted transaction
    always @(posedge aclk) begin : drive_samples
        sample_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_codes.push_back(step_controller(s_voltage_mv, s_current_ma));
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pending_samples.pop_front();
                    s_valid      <= 1'b1;
                    s_voltage_mv <= nxt.voltage_mv;
                    s_current_ma <= nxt.current_ma;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: stall at random and check each code transaction
    always @(posedge aclk) begin : check_codes
        logic [DAC_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected dac_code %0d at %0t", m_dac_code, $time);
                end else begin
                    want = expected_codes.pop_front();
                    if (m_dac_code !== want) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("dac_code mismatch at %0t: expected %0d, got %0d",
                                     $time, want, m_dac_code);
                    end
                end
            end
        end
    end

    // Write one register and mirror it; a known register clears the integral
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic known;
        known = 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LOAD_MODE:  mode_cr = val[0];
            REG_SETPOINT:   setp    = val[SETP_W-1:0];
            REG_FORCE_STOP: stop    = val[0];
            REG_PROP_GAIN:  kp      = val[PGAIN_W-1:0];
            REG_INT_GAIN:   ki      = val[IGAIN_W-1:0];
            default:        known   = 1'b0;
        endcase
        if (known)
            integ = '0;
        @(negedge aclk);
    endtask

    task automatic push_sample(input logic [VOLT_W-1:0] v, input logic [CUR_W-1:0] c);
        sample_t smp;
        smp.voltage_mv = v;
        smp.current_ma = c;
        pending_samples.push_back(smp);
        n_sent++;
    endtask

    // Hold until every queued sample is taken and every code has come back
    task automatic wait_drain();
        do
            @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_codes.size() != 0);
    endtask

    // Mostly samples just under the target so the loop integrates
    task automatic gen_sample();
        logic [VOLT_W-1:0] v;
        logic [CUR_W-1:0]  c;
        logic [SETP_W-1:0] tgt;
        int unsigned       gap;
        case ($urandom_range(0, 9))
            0:       v = VOLT_W'($urandom_range(0, 120));
            1:       v = '1;
            default: v = VOLT_W'($urandom);
        endcase
        tgt = load_target(v);
        case ($urandom_range(0, 9))
            0, 1: c = CUR_W'($urandom);
            2:    c = (tgt > SETP_W'(16'hFFFF)) ? '1 : CUR_W'(tgt);
            default: begin
                gap = $urandom_range(1, 1 << $urandom_range(0, 14));
                if (tgt <= gap)
                    c = '0;
                else if (tgt - gap > 16'hFFFF)
                    c = '1;
                else
                    c = CUR_W'(tgt - gap);
            end
        endcase
        push_sample(v, c);
    endtask

    // Pick a fresh register set, extremes included
    task automatic shuffle_config();
        logic                  cr;
        logic [CFG_DATA_W-1:0] wd;
        cr = 1'($urandom_range(0, 1));
        wd = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
        wd[0] = cr;
        write_reg(REG_LOAD_MODE, wd);
        if (!cr) begin
            case ($urandom_range(0, 4))
                0:       wd = CFG_DATA_W'($urandom_range(0, 2000));
                1:       wd = CFG_DATA_W'($urandom_range(60000, 1048575));
                2:       wd = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default: wd = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0:       wd = CFG_DATA_W'($urandom_range(0, 999));
                1:       wd = CFG_DATA_W'($urandom_range(1000, 5000));
                2:       wd = CFG_DATA_W'($urandom_range(100000, 1048575));
                3:       wd = ($urandom_range(0, 1) != 0) ? '1 : CFG_DATA_W'(CR_MIN_MOHM);
                default: wd = CFG_DATA_W'($urandom_range(1000, 100000));
            endcase
        end
        write_reg(REG_SETPOINT, wd);
        write_reg(REG_FORCE_STOP, CFG_DATA_W'($urandom_range(0, 7) == 0));
        case ($urandom_range(0, 3))
            0:       wd = ($urandom_range(0, 1) != 0) ? '1 : '0;
            1:       wd = CFG_DATA_W'($urandom_range(0, 70000));
            default: wd = CFG_DATA_W'($urandom_range(0, 262143));
        endcase
        write_reg(REG_PROP_GAIN, wd);
        case ($urandom_range(0, 3))
            0:       wd = ($urandom_range(0, 1) != 0) ? '1 : '0;
            1:       wd = CFG_DATA_W'($urandom_range(0, 2000));
            default: wd = CFG_DATA_W'($urandom_range(0, 65535));
        endcase
        write_reg(REG_INT_GAIN, wd);
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      CFG_DATA_W'($urandom));
    endtask

    initial begin : timeout
        #(TIMEOUT_NS);
        $display("electronic_load_pi_controller_unit_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values: CC mode with zero setpoint gives no drive
        push_sample(16'h0000, 16'h0000);
        push_sample(16'hFFFF, 16'hFFFF);
        wait_drain();

        // Full-scale CC setpoint saturates the code
        write_reg(REG_SETPOINT, '1);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'hFFFF, 16'hFFFF);
        wait_drain();

        // Error of one, zero and negative
        write_reg(REG_SETPOINT, 20'd1000);
        push_sample(16'h0000, 16'd999);
        push_sample(16'h0000, 16'd1000);
        push_sample(16'h0000, 16'd1001);
        push_sample(16'h0000, 16'd999);
        wait_drain();

        // Force stop, then release and integrate across a spare-register write
        write_reg(REG_FORCE_STOP, 20'd1);
        push_sample(16'h0000, 16'h0000);
        wait_drain();
        write_reg(REG_FORCE_STOP, '0);
        push_sample(16'h0000, 16'h0000);
        wait_drain();
        write_reg(REG_SPARE_FIRST, '1);
        push_sample(16'h0000, 16'h0000);
        wait_drain();
        write_reg(REG_SPARE_LAST, '1);

        // CR mode: low resistance, low voltage, then the divider extremes
        write_reg(REG_LOAD_MODE, '1);
        write_reg(REG_SETPOINT, 20'd999);
        push_sample(16'd5000, 16'h0000);
        wait_drain();
        write_reg(REG_SETPOINT, 20'd1000);
        push_sample(16'd100, 16'h0000);
        push_sample(16'd101, 16'h0000);
        push_sample(16'hFFFF, 16'h0000);
        wait_drain();
        write_reg(REG_SETPOINT, '1);
        push_sample(16'hFFFF, 16'h0000);
        wait_drain();

        // Largest and zero gains
        write_reg(REG_PROP_GAIN, '1);
        write_reg(REG_INT_GAIN, '1);
        write_reg(REG_SETPOINT, 20'd1000);
        push_sample(16'hFFFF, 16'd100);
        push_sample(16'd5000, 16'd4999);
        wait_drain();
        write_reg(REG_PROP_GAIN, '0);
        write_reg(REG_INT_GAIN, '0);
        push_sample(16'hFFFF, 16'h0000);
        wait_drain();

        // Random phases
        phase = 0;
        while (n_sent < ITEMS) begin
            phase++;
            if (phase == 3) begin
                // Wind the integral up against its clamp, visible through a tiny int gain
                write_reg(REG_LOAD_MODE, '0);
                write_reg(REG_SETPOINT, '1);
                write_reg(REG_FORCE_STOP, '0);
                write_reg(REG_PROP_GAIN, '0);
                write_reg(REG_INT_GAIN, CFG_DATA_W'($urandom_range(1, 3)));
                len = 120;
            end else begin
                if ($urandom_range(0, 3) != 0)
                    shuffle_config();
                len = $urandom_range(15, 80);
            end
            steady = (phase == 5);
            if (steady)
                len = 200;
            repeat (len)
                gen_sample();
            if (phase == 8) begin
                // Stall the receiver while samples keep coming
                @(posedge aclk);
                hold_go <= 1'b1;
                @(posedge aclk);
                hold_go <= 1'b0;
            end
            wait_drain();
            steady = 1'b0;
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_codes.size() != 0)
            n_errors++;
        if (n_errors == 0)
            $display("electronic_load_pi_controller_unit_tb: done, clean");
        else
            $display("electronic_load_pi_controller_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/elpi_pkg.sv
sv/elpi_div.sv
sv/electronic_load_pi_controller_unit.sv
tb/sv/electronic_load_pi_controller_unit_tb.sv
